// ===== rtl/upnd_pkg.sv =====
package upnd_pkg;

    // Characters that steer the decoder.
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Width of the change count as it leaves the block.
    localparam int CNT_OUT_W = 16;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [7:0]           path_byte;
        logic                 path_valid;
        logic [7:0]           ext_byte;
        logic                 ext_valid;
        logic                 ext_restart;
        logic [CNT_OUT_W-1:0] change_count;
        logic                 out_last;
    } result_t;

    // Path context that a plain byte reads and updates.
    typedef struct packed {
        logic [7:0] prev;
        logic       nonempty;
        logic       ext_active;
    } path_ctx_t;

    // Outcome of handling one byte as a plain character.
    typedef struct packed {
        logic       emit;
        logic       pv;
        logic [7:0] pb;
        logic       ev;
        logic [7:0] eb;
        logic       er;
        logic       pct;
        path_ctx_t  ctx;
    } plain_t;

    // Up to two result words pushed per accepted input word.
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
    endfunction

    function automatic plain_t plain_eval(input logic [7:0] b, input path_ctx_t ctx);
        plain_t r;
        r     = '0;
        r.ctx = ctx;
        priority if (b == CH_SLASH || b == CH_BSLASH)
        begin
            r.emit           = 1'b1;
            r.pv             = ctx.nonempty && (ctx.prev != CH_SLASH);
            r.pb             = CH_SLASH;
            r.er             = 1'b1;
            r.ctx.ext_active = 1'b0;
        end
        else if (b == CH_DOT)
        begin
            r.emit           = 1'b1;
            r.pv             = ctx.nonempty && (ctx.prev != CH_DOT);
            r.pb             = CH_DOT;
            r.ev             = 1'b1;
            r.eb             = CH_DOT;
            r.er             = 1'b1;
            r.ctx.ext_active = 1'b1;
        end
        else if (b == CH_PCT)
        begin
            r.pct = 1'b1;
        end
        else if (b == CH_PLUS)
        begin
            r.emit = 1'b1;
            r.pv   = 1'b1;
            r.pb   = CH_SPACE;
        end
        else
        begin
            r.emit = 1'b1;
            r.pv   = 1'b1;
            r.pb   = b;
            r.ev   = ctx.ext_active;
            r.eb   = ctx.ext_active ? to_lower(b) : 8'h00;
        end
        if (r.pv)
        begin
            r.ctx.prev     = r.pb;
            r.ctx.nonempty = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/upnd_if.sv =====
interface upnd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upnd_out_if;
    import upnd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [7:0]           path_byte;
    logic                 path_valid;
    logic [7:0]           ext_byte;
    logic                 ext_valid;
    logic                 ext_restart;
    logic [CNT_OUT_W-1:0] change_count;
    logic                 out_last;

    modport source (output valid, output path_byte, output path_valid, output ext_byte,
                    output ext_valid, output ext_restart, output change_count,
                    output out_last, input ready);
    modport sink   (input valid, input path_byte, input path_valid, input ext_byte,
                    input ext_valid, input ext_restart, input change_count,
                    input out_last, output ready);
endinterface

// ===== rtl/upnd_core.sv =====
module upnd_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output upnd_pkg::push_t push
);
    import upnd_pkg::*;

    logic                   pend_reg, pend_next;
    logic                   held_v_reg, held_v_next;
    logic [7:0]             held_reg, held_next;
    logic [7:0]             prev_reg;
    logic                   nonempty_reg;
    logic                   ext_reg;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [CNT_OUT_W-1:0]   shown;

    path_ctx_t ctx, ctx_a, ctx_b;
    plain_t    pa, pb;
    logic      a_use, b_use, dec_hit, a_emit, b_emit, empty_emit;
    logic [7:0] a_byte, b_byte, dec_val;
    result_t   ra, rb;

    always_comb
    begin
        ctx         = '{prev: prev_reg, nonempty: nonempty_reg, ext_active: ext_reg};
        pend_next   = pend_reg;
        held_v_next = held_v_reg;
        held_next   = held_reg;
        total_next  = total_reg;
        a_use       = 1'b0;
        a_byte      = in_byte;
        b_use       = 1'b0;
        b_byte      = in_byte;
        dec_hit     = 1'b0;
        dec_val     = {hex_val(held_reg), hex_val(in_byte)};

        // Escape state: first digit, second digit, or a plain byte.
        if (pend_reg && !held_v_reg)
        begin
            if (is_hex(in_byte))
            begin
                held_next   = in_byte;
                held_v_next = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
                a_use     = 1'b1;
            end
        end
        else if (pend_reg)
        begin
            pend_next   = 1'b0;
            held_v_next = 1'b0;
            if (is_hex(in_byte))
            begin
                dec_hit = 1'b1;
                if (total_reg != '1)
                begin
                    total_next = total_reg + 1'b1;
                end
            end
            else
            begin
                // Bad escape: the held digit and this byte both go out plain.
                a_use  = 1'b1;
                a_byte = held_reg;
                b_use  = 1'b1;
            end
        end
        else
        begin
            a_use = 1'b1;
        end

        pa = plain_eval(a_byte, ctx);
        if (a_use && pa.pct)
        begin
            pend_next   = 1'b1;
            held_v_next = 1'b0;
        end
        a_emit = (a_use && pa.emit) || dec_hit;
        if (a_use)
        begin
            ctx_a = pa.ctx;
        end
        else if (dec_hit)
        begin
            ctx_a = '{prev: dec_val, nonempty: 1'b1, ext_active: ext_reg};
        end
        else
        begin
            ctx_a = ctx;
        end

        // A digit still held at the end of the path goes out plain.
        if (in_last && pend_next && held_v_next)
        begin
            b_use  = 1'b1;
            b_byte = held_next;
        end

        pb = plain_eval(b_byte, ctx_a);
        if (b_use && pb.pct)
        begin
            pend_next   = 1'b1;
            held_v_next = 1'b0;
        end
        b_emit = b_use && pb.emit;
        ctx_b  = b_use ? pb.ctx : ctx_a;

        empty_emit = in_last && !a_emit && !b_emit;

        ra = '0;
        ra.change_count = shown;
        if (dec_hit)
        begin
            ra.path_byte  = dec_val;
            ra.path_valid = 1'b1;
        end
        else if (!empty_emit)
        begin
            ra.path_byte   = pa.pv ? pa.pb : 8'h00;
            ra.path_valid  = pa.pv;
            ra.ext_byte    = pa.ev ? pa.eb : 8'h00;
            ra.ext_valid   = pa.ev;
            ra.ext_restart = pa.er;
        end
        ra.out_last = in_last && !b_emit;

        rb              = '0;
        rb.path_byte    = pb.pv ? pb.pb : 8'h00;
        rb.path_valid   = pb.pv;
        rb.ext_byte     = pb.ev ? pb.eb : 8'h00;
        rb.ext_valid    = pb.ev;
        rb.ext_restart  = pb.er;
        rb.change_count = shown;
        rb.out_last     = in_last;

        push.r0 = (a_emit || empty_emit) ? ra : rb;
        push.r1 = rb;
        if (!fire)
        begin
            push.n = 2'd0;
        end
        else
        begin
            push.n = 2'({1'b0, a_emit || empty_emit}) + 2'({1'b0, b_emit});
        end
    end

    generate
        if (COUNT_WIDTH > CNT_OUT_W)
        begin : g_cap
            assign shown = (|total_next[COUNT_WIDTH-1:CNT_OUT_W]) ? '1
                                                                   : total_next[CNT_OUT_W-1:0];
        end
        else
        begin : g_ext
            assign shown = CNT_OUT_W'(total_next);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            held_v_reg   <= 1'b0;
            held_reg     <= 8'h00;
            prev_reg     <= 8'h00;
            nonempty_reg <= 1'b0;
            ext_reg      <= 1'b0;
            total_reg    <= '0;
        end
        else if (fire)
        begin
            ext_reg <= ctx_b.ext_active;
            if (in_last)
            begin
                pend_reg     <= 1'b0;
                held_v_reg   <= 1'b0;
                held_reg     <= 8'h00;
                prev_reg     <= 8'h00;
                nonempty_reg <= 1'b0;
                total_reg    <= '0;
            end
            else
            begin
                pend_reg     <= pend_next;
                held_v_reg   <= held_v_next;
                held_reg     <= held_next;
                prev_reg     <= ctx_b.prev;
                nonempty_reg <= ctx_b.nonempty;
                total_reg    <= total_next;
            end
        end
    end

endmodule

// ===== rtl/upnd_fifo.sv =====
module upnd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  upnd_pkg::push_t   push,
    input  logic              pop,
    output upnd_pkg::result_t head,
    output logic              not_empty,
    output logic              has_room
);
    import upnd_pkg::*;

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_reg;
    logic [FIFO_PTR_W-1:0]  rd_reg;
    logic [FIFO_CNT_W-1:0]  cnt_reg;
    logic [FIFO_PTR_W-1:0]  wr_plus1;

    assign wr_plus1  = wr_reg + 1'b1;
    assign head      = mem[rd_reg];
    assign not_empty = (cnt_reg != '0);
    // Room for the two words that one input word can cause.
    assign has_room  = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[wr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem[wr_plus1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + FIFO_PTR_W'(push.n);
            cnt_reg <= cnt_reg + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/uri_path_normalizing_decoder.sv =====
// Channel | Dir | Fields
// --------+-----+-----------------------------------------------------------------
// enc     | in  | in_byte, in_last: one encoded path byte per word
// dec     | out | path_byte, path_valid, ext_byte, ext_valid, ext_restart,
//         |     | change_count, out_last: one decoded result per word
//
// An input word is decoded in the cycle it is accepted; its results land in a four-word
// result queue, and when the queue was empty the first one shows on dec in the next cycle.
// A byte gives zero, one or two result words, and two only after two bytes that gave none,
// so with dec.ready high the queue never holds more than two words and enc never stalls.
// Input ready is high whenever the queue has room for two words, independent of dec.ready.
// Reset clears the escape state, the path context, the counter and the queue.
module uri_path_normalizing_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    upnd_in_if.sink           enc,
    upnd_out_if.source        dec
);
    import upnd_pkg::*;

    logic    fire;
    logic    pop;
    logic    not_empty;
    logic    has_room;
    push_t   push;
    result_t head;

    // The input word is taken when the queue can hold everything it may produce.
    assign enc.ready = has_room;
    assign fire      = enc.valid && has_room;

    // Escape handling, plus-to-space mapping, separator folding, extension tracking and change counting.
    upnd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (enc.in_byte),
        .in_last (enc.in_last),
        .push    (push)
    );

    // The queue decouples the two sides: a stalled output does not stop input
    // until the queue is nearly full.
    assign pop = not_empty && dec.ready;

    upnd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign dec.valid        = not_empty;
    assign dec.path_byte    = head.path_byte;
    assign dec.path_valid   = head.path_valid;
    assign dec.ext_byte     = head.ext_byte;
    assign dec.ext_valid    = head.ext_valid;
    assign dec.ext_restart  = head.ext_restart;
    assign dec.change_count = head.change_count;
    assign dec.out_last     = head.out_last;

endmodule

// ===== rtl/upnd_checker.sv =====
module upnd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        enc_ready,
    input logic        dec_valid,
    input logic        dec_ready,
    input logic [7:0]  path_byte,
    input logic        path_valid,
    input logic [7:0]  ext_byte,
    input logic        ext_valid,
    input logic        ext_restart,
    input logic [15:0] change_count,
    input logic        out_last
);
    import upnd_pkg::*;

    // A stalled output word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |=> dec_valid && $stable(path_byte) &&
        $stable(ext_byte) && $stable(change_count) && $stable(out_last))
        else $error("output word changed while stalled");

    // A result that carries nothing only closes a path.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !path_valid && !ext_valid && !ext_restart |-> out_last)
        else $error("empty result that is not the last of its path");

    // Extension bytes are lowercase.
    a_lower: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && ext_valid |-> (ext_byte < 8'h41) || (ext_byte > 8'h5A))
        else $error("uppercase extension byte");

    // A restart that adds a byte starts a new extension with a dot.
    a_restart_dot: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && ext_valid && ext_restart |-> ext_byte == CH_DOT)
        else $error("extension restarted with a byte other than a dot");

    // With no output pending, input is always taken.
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !dec_valid |-> enc_ready)
        else $error("input stalled while the output is empty");

endmodule

bind uri_path_normalizing_decoder upnd_checker u_upnd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .enc_ready    (enc.ready),
    .dec_valid    (dec.valid),
    .dec_ready    (dec.ready),
    .path_byte    (dec.path_byte),
    .path_valid   (dec.path_valid),
    .ext_byte     (dec.ext_byte),
    .ext_valid    (dec.ext_valid),
    .ext_restart  (dec.ext_restart),
    .change_count (dec.change_count),
    .out_last     (dec.out_last)
);
